>>> rtl/core/wfps_pkg.sv
// shared types, constants and merge functions for the prefetch scheduler
package wfps_pkg;

   localparam int TDATA_W = 112;
   localparam int TAG_W = 64;
   localparam int WEIGHT_W = 32;
   localparam int SCALE_W = 24;
   localparam int FINISH_W = 64;
   localparam logic [SCALE_W-1:0] WEIGHT_SCALE_RESET = 24'd1000000;

   // one stored object of a batch
   typedef struct packed {
      logic [TAG_W-1:0]    tag;
      logic [WEIGHT_W-1:0] weight;
      logic [WEIGHT_W-1:0] reason_weight;
      logic [3:0]          reason;
      logic [1:0]          frame_class;
      logic                present;
      logic                blocked;
   } entry_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic inc_idx;
      logic rd;
      logic wr_merge;
      logic wr_new;
      logic clr_run;
      logic rst_run;
      logic base_step;
      logic inc_run;
      logic drop_run;
      logic take_offer;
      logic commit_run;
      logic finish;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic active;
      logic last;
      logic idx_at_count;
      logic list_full;
      logic tag_match;
      logic present;
      logic blocked;
      logic run_at_end;
      logic div_done;
      logic out_busy;
   } ctrl_status_type;

   // fresh entry for a newly seen object
   function automatic entry_type fresh_entry(logic [TAG_W-1:0] tag, logic [1:0] fc,
                                             logic pres, logic blk);
      entry_type e;
      e.tag = tag;
      e.weight = '0;
      e.reason_weight = '0;
      e.reason = '0;
      e.frame_class = fc;
      e.present = pres;
      e.blocked = blk;
      return e;
   endfunction

   // fold one hint into an entry
   function automatic entry_type merge_hint(entry_type e, logic [WEIGHT_W-1:0] w,
                                            logic [1:0] fc, logic [3:0] rc);
      entry_type m;
      logic [WEIGHT_W:0] sum;
      m = e;
      sum = {1'b0, e.weight} + {1'b0, w};
      m.weight = sum[WEIGHT_W] ? {WEIGHT_W{1'b1}} : sum[WEIGHT_W-1:0];
      if (w >= e.reason_weight) begin
         m.reason_weight = w;
         m.reason = rc;
      end
      if (fc < e.frame_class) begin
         m.frame_class = fc;
      end
      return m;
   endfunction

endpackage

>>> rtl/core/weighted_fair_prefetch_scheduler.sv
// top level of the weighted fair prefetch scheduler
//
// Hint entries arrive on the req_ stream, one per request; req_tlast marks the
// last entry of a batch. Entries are merged per run into an object store. On
// the last entry the block picks one run by virtual finish time and sends a
// single result on the rsp_ stream (request_valid low when nothing is ready).
// The csr_ channel writes weight_scale; it is always ready. The user must write
// it only while the block is idle; the block itself does not enforce this.
// Each hint reads and compares the stored entries of its run one at a time, a
// store read and a compare each, until a tag matches or the list ends. Ending a
// batch runs a base search over the RUN_SLOTS runs, then per run inspects its
// entries in turn and moves on; each run that offers an object uses the shared
// bit-serial divider, and the result is loaded into the output register last.
// Reset clears all run finish times, valid flags and counts; weight_scale goes
// to 1000000. The store needs no clearing. A stalled rsp_ side holds the result
// register; loading of new hints continues, and the next batch end waits until
// the register is free.
module weighted_fair_prefetch_scheduler
   import wfps_pkg::*;
#(
   parameter int RUN_SLOTS = 8,
   parameter int OBJECTS_PER_RUN = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // run_index[2:0], object_id[66:3], hint_weight[98:67], frame_class[100:99],
   // reason_code[104:101], object_present[105], object_blocked[106], zero fill
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,
   input  logic               req_tlast,
   // request_valid[0], chosen_run[3:1], chosen_object[67:4],
   // sequence_position[71:68], chosen_weight[103:72], chosen_reason[107:104],
   // chosen_frame_class[109:108], zero fill
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SCALE_W-1:0] csr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   wfps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wfps_dpath #(
      .RUN_SLOTS       (RUN_SLOTS),
      .OBJECTS_PER_RUN (OBJECTS_PER_RUN),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

>>> rtl/core/wfps_ram.sv
// generic single write, single read ram with registered read data
module wfps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/wfps_div.sv
// radix-2 restoring divider, one quotient bit a cycle
module wfps_div #(
   parameter int DIVIDEND_W = 40,
   parameter int DIVISOR_W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   // one shift and trial subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff = trial - {1'b0, div_ff};
      ge = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(DIVIDEND_W);
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

   // a new division is never launched over a running one
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");

endmodule

>>> rtl/core/wfps_ctrl.sv
// sequencing state machine for hint loading and end-of-batch selection
module wfps_ctrl
   import wfps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SEARCH    = 4'd1;
   localparam logic [3:0] S_CMP       = 4'd2;
   localparam logic [3:0] S_BASE      = 4'd3;
   localparam logic [3:0] S_SCAN      = 4'd4;
   localparam logic [3:0] S_OFFER_CMP = 4'd5;
   localparam logic [3:0] S_DIV       = 4'd6;
   localparam logic [3:0] S_NEXT      = 4'd7;
   localparam logic [3:0] S_FINISH    = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       item_end;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      item_end = 1'b0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (!status.active) begin
               item_end = 1'b1;
            end else if (status.idx_at_count) begin
               cmd.wr_new = !status.list_full;
               item_end = 1'b1;
            end else begin
               cmd.rd = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (status.tag_match) begin
               cmd.wr_merge = 1'b1;
               item_end = 1'b1;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_BASE: begin
            cmd.base_step = 1'b1;
            if (status.run_at_end) begin
               cmd.rst_run = 1'b1;
               state_in = S_SCAN;
            end else begin
               cmd.inc_run = 1'b1;
            end
         end
         S_SCAN: begin
            if (status.idx_at_count) begin
               cmd.drop_run = 1'b1;
               state_in = S_NEXT;
            end else begin
               cmd.rd = 1'b1;
               state_in = S_OFFER_CMP;
            end
         end
         S_OFFER_CMP: begin
            if (status.present) begin
               cmd.inc_idx = 1'b1;
               state_in = S_SCAN;
            end else if (status.blocked) begin
               cmd.drop_run = 1'b1;
               state_in = S_NEXT;
            end else begin
               cmd.take_offer = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.commit_run = 1'b1;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (status.run_at_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.inc_run = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_FINISH: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // close the request: end the batch or wait for the next one
      if (item_end) begin
         if (status.last) begin
            cmd.clr_run = 1'b1;
            state_in = S_BASE;
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // result is only loaded into a free output register
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.out_busy) else $error("result loaded over pending result");

   // the store is never read and written in one cycle
   a_rd_wr: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_new || cmd.wr_merge) |-> !cmd.rd) else $error("store read and write clash");

endmodule

>>> rtl/core/wfps_dpath.sv
// datapath: batch store, per-run counts and finish times, divider, output register
module wfps_dpath
   import wfps_pkg::*;
#(
   parameter int RUN_SLOTS = 8,
   parameter int OBJECTS_PER_RUN = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [TDATA_W-1:0]  req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata,
   input  logic                csr_valid,
   input  logic [SCALE_W-1:0]  csr_data,
   input  ctrl_cmd_type        cmd,
   output ctrl_status_type     status
);

   localparam int RUN_W = $clog2(RUN_SLOTS);
   localparam int IDX_W = $clog2(OBJECTS_PER_RUN + 1);
   localparam int DEPTH = RUN_SLOTS * OBJECTS_PER_RUN;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DIVD_W = SCALE_W + FRACTION_BITS;

   // request fields
   logic [2:0]          in_run;
   logic [TAG_W-1:0]    in_tag;
   logic [WEIGHT_W-1:0] in_weight;
   logic [1:0]          in_fc;
   logic [3:0]          in_rc;
   logic                in_pres;
   logic                in_blk;

   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [RUN_W-1:0]    run_ff, run_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    cnt_ff [RUN_SLOTS];
   logic [IDX_W-1:0]    cnt_in [RUN_SLOTS];
   logic [FINISH_W-1:0] ft_ff [RUN_SLOTS];
   logic [FINISH_W-1:0] ft_in [RUN_SLOTS];
   logic                fv_ff [RUN_SLOTS];
   logic                fv_in [RUN_SLOTS];
   logic                active_ff, active_in;
   logic                last_ff, last_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [WEIGHT_W-1:0] wt_ff, wt_in;
   logic [1:0]          fc_ff, fc_in;
   logic [3:0]          rc_ff, rc_in;
   logic                pres_ff, pres_in;
   logic                blk_ff, blk_in;
   logic [FINISH_W-1:0] base_ff, base_in;
   logic                have_ff, have_in;
   logic                found_ff, found_in;
   entry_type           off_rec_ff, off_rec_in;
   logic [IDX_W-1:0]    off_pos_ff, off_pos_in;
   entry_type           best_rec_ff, best_rec_in;
   logic [IDX_W-1:0]    best_pos_ff, best_pos_in;
   logic [RUN_W-1:0]    best_run_ff, best_run_in;
   logic [FINISH_W-1:0] best_f_ff, best_f_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]   addr;
   logic [$bits(entry_type)-1:0] ram_wdata;
   logic [$bits(entry_type)-1:0] ram_rdata;
   entry_type           rd_rec;
   logic                ram_wr;
   logic [IDX_W-1:0]    cnt_cur;
   logic [FINISH_W-1:0] start_t;
   logic [FINISH_W:0]   sum_f;
   logic [FINISH_W-1:0] fin;
   logic                div_done;
   logic [DIVD_W-1:0]   quotient;
   logic [WEIGHT_W-1:0] divisor;
   logic [IDX_W+3:0]    pos_ext;
   logic [RUN_W+2:0]    run_ext;

   assign in_run = req_tdata[2:0];
   assign in_tag = req_tdata[66:3];
   assign in_weight = req_tdata[98:67];
   assign in_fc = req_tdata[100:99];
   assign in_rc = req_tdata[104:101];
   assign in_pres = req_tdata[105];
   assign in_blk = req_tdata[106];

   assign rd_rec = entry_type'(ram_rdata);
   assign cnt_cur = cnt_ff[run_ff];
   assign addr = ADDR_W'(run_ff * OBJECTS_PER_RUN) + ADDR_W'(idx_ff);
   assign divisor = (rd_rec.weight == '0) ? WEIGHT_W'(1) : rd_rec.weight;

   // start point and saturating finish time of the offering run
   always_comb begin
      if (fv_ff[run_ff]) begin
         start_t = ft_ff[run_ff];
      end else if (have_ff) begin
         start_t = base_ff;
      end else begin
         start_t = '0;
      end
      sum_f = {1'b0, start_t} + (FINISH_W + 1)'(quotient);
      fin = sum_f[FINISH_W] ? {FINISH_W{1'b1}} : sum_f[FINISH_W-1:0];
   end

   // store write data
   always_comb begin
      ram_wr = cmd.wr_new || cmd.wr_merge;
      if (cmd.wr_new) begin
         ram_wdata = merge_hint(fresh_entry(tag_ff, fc_ff, pres_ff, blk_ff), wt_ff,
                                fc_ff, rc_ff);
      end else begin
         ram_wdata = merge_hint(rd_rec, wt_ff, fc_ff, rc_ff);
      end
   end

   // next values
   always_comb begin
      scale_in = csr_valid ? csr_data : scale_ff;
      run_in = run_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      ft_in = ft_ff;
      fv_in = fv_ff;
      active_in = active_ff;
      last_in = last_ff;
      tag_in = tag_ff;
      wt_in = wt_ff;
      fc_in = fc_ff;
      rc_in = rc_ff;
      pres_in = pres_ff;
      blk_in = blk_ff;
      base_in = base_ff;
      have_in = have_ff;
      found_in = found_ff;
      off_rec_in = off_rec_ff;
      off_pos_in = off_pos_ff;
      best_rec_in = best_rec_ff;
      best_pos_in = best_pos_ff;
      best_run_in = best_run_ff;
      best_f_in = best_f_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      pos_ext = {4'd0, best_pos_ff};
      run_ext = {3'd0, best_run_ff};

      // latch an accepted request
      if (cmd.load_req) begin
         run_in = RUN_W'(in_run);
         idx_in = '0;
         active_in = (in_weight != '0) && ({29'd0, in_run} < RUN_SLOTS);
         last_in = req_tlast;
         tag_in = in_tag;
         wt_in = in_weight;
         fc_in = in_fc;
         rc_in = in_rc;
         pres_in = in_pres;
         blk_in = in_blk;
      end
      if (cmd.inc_idx) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.wr_new) begin
         cnt_in[run_ff] = cnt_cur + 1'b1;
      end
      // batch end bookkeeping
      if (cmd.clr_run) begin
         run_in = '0;
         idx_in = '0;
         have_in = 1'b0;
         found_in = 1'b0;
      end
      if (cmd.base_step) begin
         if (cnt_cur != '0 && fv_ff[run_ff] && (!have_ff || ft_ff[run_ff] < base_ff)) begin
            base_in = ft_ff[run_ff];
            have_in = 1'b1;
         end
      end
      if (cmd.rst_run) begin
         run_in = '0;
         idx_in = '0;
      end
      if (cmd.inc_run) begin
         run_in = run_ff + 1'b1;
         idx_in = '0;
      end
      if (cmd.drop_run) begin
         fv_in[run_ff] = 1'b0;
         ft_in[run_ff] = '0;
      end
      if (cmd.take_offer) begin
         off_rec_in = rd_rec;
         off_pos_in = idx_ff;
      end
      if (cmd.commit_run) begin
         ft_in[run_ff] = start_t;
         fv_in[run_ff] = 1'b1;
         if (!found_ff || fin < best_f_ff) begin
            found_in = 1'b1;
            best_f_in = fin;
            best_run_in = run_ff;
            best_rec_in = off_rec_ff;
            best_pos_in = off_pos_ff;
         end
      end
      // result hand-off
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (found_ff) begin
            rsp_data_in = {2'd0, best_rec_ff.frame_class, best_rec_ff.reason,
                           best_rec_ff.weight, pos_ext[3:0], best_rec_ff.tag,
                           run_ext[2:0], 1'b1};
            ft_in[best_run_ff] = best_f_ff;
         end else begin
            rsp_data_in = '0;
         end
         for (int r = 0; r < RUN_SLOTS; r++) begin
            cnt_in[r] = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= WEIGHT_SCALE_RESET;
         rsp_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         have_ff <= 1'b0;
         for (int r = 0; r < RUN_SLOTS; r++) begin
            cnt_ff[r] <= '0;
            fv_ff[r] <= 1'b0;
            ft_ff[r] <= '0;
         end
      end else begin
         scale_ff <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff <= found_in;
         have_ff <= have_in;
         cnt_ff <= cnt_in;
         fv_ff <= fv_in;
         ft_ff <= ft_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      run_ff <= run_in;
      idx_ff <= idx_in;
      active_ff <= active_in;
      last_ff <= last_in;
      tag_ff <= tag_in;
      wt_ff <= wt_in;
      fc_ff <= fc_in;
      rc_ff <= rc_in;
      pres_ff <= pres_in;
      blk_ff <= blk_in;
      base_ff <= base_in;
      off_rec_ff <= off_rec_in;
      off_pos_ff <= off_pos_in;
      best_rec_ff <= best_rec_in;
      best_pos_ff <= best_pos_in;
      best_run_ff <= best_run_in;
      best_f_ff <= best_f_in;
      rsp_data_ff <= rsp_data_in;
   end

   wfps_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (addr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd),
      .rd_addr (addr),
      .rd_data (ram_rdata)
   );

   wfps_div #(
      .DIVIDEND_W (DIVD_W),
      .DIVISOR_W  (WEIGHT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.take_offer),
      .dividend (DIVD_W'(scale_ff) << FRACTION_BITS),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // status to the controller
   always_comb begin
      status.active = active_ff;
      status.last = last_ff;
      status.idx_at_count = (idx_ff == cnt_cur);
      status.list_full = (cnt_cur == IDX_W'(OBJECTS_PER_RUN));
      status.tag_match = (rd_rec.tag == tag_ff);
      status.present = rd_rec.present;
      status.blocked = rd_rec.blocked;
      status.run_at_end = (run_ff == RUN_W'(RUN_SLOTS - 1));
      status.div_done = div_done;
      status.out_busy = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // a new object is only appended below the list capacity
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_new |-> cnt_cur < IDX_W'(OBJECTS_PER_RUN)) else $error("object list overfilled");

endmodule

>>> sim/weighted_fair_prefetch_scheduler_checker.sv
// checker for the prefetch scheduler: predicts batch results and compares them
`timescale 1ns / 100ps

module weighted_fair_prefetch_scheduler_checker
   import wfps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,
   input  logic               req_tlast,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [TDATA_W-1:0] rsp_tdata,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [SCALE_W-1:0] csr_data,
   output int                 fail_count,
   output int                 pending_count
);

   localparam int RUNS = 8;
   localparam int DEPTH = 16;
   localparam int FRAC = 16;

   // one predicted scheduling decision
   typedef struct packed {
      logic              granted;
      logic [2:0]        run;
      logic [TAG_W-1:0]  tag;
      logic [3:0]        position;
      logic [WEIGHT_W-1:0] weight;
      logic [3:0]        reason;
      logic [1:0]        frame_class;
   } decision_type;

   logic [SCALE_W-1:0]  scale;
   logic [FINISH_W-1:0] finish_time [RUNS];
   logic                finish_known [RUNS];
   int                  list_len [RUNS];
   entry_type           store [RUNS][DEPTH];
   decision_type        expected_decisions [$];

   assign pending_count = expected_decisions.size();

   // merge one hint into the predicted run lists
   task automatic fold_hint(input logic [TDATA_W-1:0] d);
      logic [2:0] run;
      logic [TAG_W-1:0] tag;
      logic [WEIGHT_W-1:0] w;
      logic [1:0] fc;
      logic [3:0] rc;
      logic [WEIGHT_W:0] sum;
      int pos;
      run = d[2:0];
      tag = d[66:3];
      w = d[98:67];
      fc = d[100:99];
      rc = d[104:101];
      if (w == 0) return;
      pos = list_len[run];
      for (int i = 0; i < list_len[run]; i++)
         if (store[run][i].tag == tag) begin
            pos = i;
            break;
         end
      if (pos == list_len[run]) begin
         if (pos >= DEPTH) return;
         store[run][pos].tag = tag;
         store[run][pos].weight = '0;
         store[run][pos].reason_weight = '0;
         store[run][pos].reason = '0;
         store[run][pos].frame_class = fc;
         store[run][pos].present = d[105];
         store[run][pos].blocked = d[106];
         list_len[run]++;
      end
      sum = {1'b0, store[run][pos].weight} + {1'b0, w};
      store[run][pos].weight = sum[WEIGHT_W] ? '1 : sum[WEIGHT_W-1:0];
      if (w >= store[run][pos].reason_weight) begin
         store[run][pos].reason_weight = w;
         store[run][pos].reason = rc;
      end
      if (fc < store[run][pos].frame_class) store[run][pos].frame_class = fc;
   endtask

   // end of batch: pick the run with least virtual finish time
   task automatic close_batch();
      logic [FINISH_W-1:0] base, adv, f, best_f, wt;
      logic [FINISH_W:0] sum;
      logic base_seen, found, offer;
      int best, pick;
      decision_type dec;
      base = '0;
      base_seen = 0;
      found = 0;
      best = 0;
      best_f = '0;
      dec = '0;
      for (int r = 0; r < RUNS; r++)
         if (list_len[r] != 0 && finish_known[r] && (!base_seen || finish_time[r] < base)) begin
            base = finish_time[r];
            base_seen = 1;
         end
      for (int r = 0; r < RUNS; r++) begin
         offer = 0;
         pick = 0;
         for (int i = 0; i < list_len[r]; i++) begin
            if (store[r][i].present) continue;
            if (!store[r][i].blocked) begin
               offer = 1;
               pick = i;
            end
            break;
         end
         if (offer) begin
            wt = store[r][pick].weight == 0 ? 64'd1 : 64'(store[r][pick].weight);
            if (!finish_known[r]) begin
               finish_time[r] = base_seen ? base : '0;
               finish_known[r] = 1;
            end
            adv = (64'(scale) << FRAC) / wt;
            sum = {1'b0, finish_time[r]} + {1'b0, adv};
            f = sum[FINISH_W] ? '1 : sum[FINISH_W-1:0];
            if (!found || f < best_f) begin
               found = 1;
               best = r;
               best_f = f;
               dec.granted = 1;
               dec.run = 3'(r);
               dec.tag = store[r][pick].tag;
               dec.position = 4'(pick);
               dec.weight = store[r][pick].weight;
               dec.reason = store[r][pick].reason;
               dec.frame_class = store[r][pick].frame_class;
            end
         end else begin
            finish_known[r] = 0;
            finish_time[r] = '0;
         end
      end
      if (found) finish_time[best] = best_f;
      for (int r = 0; r < RUNS; r++) list_len[r] = 0;
      expected_decisions.insert(expected_decisions.size(), dec);
   endtask

   // one line per mismatch
   task automatic report(input string what, input logic [TAG_W-1:0] got,
                         input logic [TAG_W-1:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // compare a result with the oldest prediction
   task automatic check_decision(input logic [TDATA_W-1:0] d);
      decision_type e;
      if (expected_decisions.size() == 0) begin
         report("unexpected result", d[63:0], '0);
         return;
      end
      e = expected_decisions[0];
      expected_decisions.delete(0);
      if (d[0] !== e.granted) report("request_valid", 64'(d[0]), 64'(e.granted));
      if (d[3:1] !== e.run) report("chosen_run", 64'(d[3:1]), 64'(e.run));
      if (d[67:4] !== e.tag) report("chosen_object", d[67:4], e.tag);
      if (d[71:68] !== e.position)
         report("sequence_position", 64'(d[71:68]), 64'(e.position));
      if (d[103:72] !== e.weight) report("chosen_weight", 64'(d[103:72]), 64'(e.weight));
      if (d[107:104] !== e.reason) report("chosen_reason", 64'(d[107:104]), 64'(e.reason));
      if (d[109:108] !== e.frame_class)
         report("chosen_frame_class", 64'(d[109:108]), 64'(e.frame_class));
   endtask

   // watch the channels
   always @(posedge clock) begin
      if (reset) begin
         scale <= WEIGHT_SCALE_RESET;
         for (int r = 0; r < RUNS; r++) begin
            finish_time[r] = '0;
            finish_known[r] = 0;
            list_len[r] = 0;
         end
         expected_decisions.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) scale <= csr_data;
         if (req_tvalid && req_tready) begin
            fold_hint(req_tdata);
            if (req_tlast) close_batch();
         end
         if (rsp_tvalid && rsp_tready) check_decision(rsp_tdata);
      end
   end

endmodule

>>> sim/weighted_fair_prefetch_scheduler_test.sv
// testbench top for the prefetch scheduler: stimulus, clock, reset and verdict
`timescale 1ns / 100ps

module weighted_fair_prefetch_scheduler_test;
   import wfps_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_tvalid = 0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;
   logic               req_tlast = 0;
   logic               rsp_tvalid;
   logic               rsp_tready = 0;
   logic [TDATA_W-1:0] rsp_tdata;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [SCALE_W-1:0] csr_data = '0;
   int                 fail_count;
   int                 pending_count;
   int                 rsp_wait = 0;

   always #5 clock = ~clock;

   weighted_fair_prefetch_scheduler DUT (.*);

   weighted_fair_prefetch_scheduler_checker checker_i (.*);

   // send one hint request, with a random gap first
   task automatic send_hint(input logic [2:0] run, input logic [63:0] tag,
                            input logic [31:0] w, input logic [1:0] fc,
                            input logic [3:0] rc, input logic pres,
                            input logic blk, input logic last);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, blk, pres, rc, fc, w, tag, run};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // wait until every predicted result has come, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // write weight_scale while idle
   task automatic write_scale(input logic [SCALE_W-1:0] v);
      drain();
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   // one random batch; mostly small runs with repeated tags
   task automatic random_batch(output int sent);
      int n;
      logic [63:0] tags [4];
      logic [31:0] w;
      for (int i = 0; i < 4; i++) tags[i] = {$urandom, $urandom};
      n = $urandom_range(1, 12);
      if ($urandom_range(0, 30) == 0) n = 40;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: w = '0;
            1: w = '1 - $urandom_range(0, 3);
            2: w = $urandom;
            default: w = $urandom_range(1, 500);
         endcase
         send_hint(3'($urandom_range(0, 7)),
                   $urandom_range(0, 9) == 0 ? {$urandom, $urandom}
                                             : tags[$urandom_range(0, 3)],
                   w, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                   $urandom_range(0, 3) == 0, $urandom_range(0, 6) == 0,
                   i == n - 1);
      end
      sent = n;
   endtask

   // result side waits a random number of cycles after each result
   always @(posedge clock) begin
      int w;
      if (rsp_tvalid && rsp_tready) begin
         w = $urandom_range(0, 13);
         rsp_wait <= w;
         rsp_tready <= (w == 0);
      end else if (rsp_wait > 1) begin
         rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_wait <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // stimulus
   initial begin
      int total, sent;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty batch, zero weight, extremes
      send_hint(3'd0, '0, 32'd0, 2'd0, 4'd0, 1'b0, 1'b0, 1'b1);
      send_hint(3'd7, '1, '1, 2'd3, 4'd15, 1'b0, 1'b0, 1'b0);
      send_hint(3'd7, '1, '1, 2'd0, 4'd4, 1'b1, 1'b1, 1'b0);
      send_hint(3'd0, 64'h1, 32'd5, 2'd2, 4'd3, 1'b0, 1'b0, 1'b0);
      send_hint(3'd1, 64'h2, 32'd1, 2'd1, 4'd9, 1'b0, 1'b1, 1'b0);
      send_hint(3'd2, 64'h3, 32'd7, 2'd0, 4'd2, 1'b1, 1'b0, 1'b0);
      send_hint(3'd2, 64'h4, 32'd7, 2'd3, 4'd6, 1'b0, 1'b0, 1'b0);
      send_hint(3'd3, 64'h5, 32'd0, 2'd0, 4'd1, 1'b0, 1'b0, 1'b1);
      // new run against an existing finish time, and ties
      send_hint(3'd0, 64'h1, 32'd5, 2'd1, 4'd7, 1'b0, 1'b0, 1'b0);
      send_hint(3'd4, 64'h9, 32'd5, 2'd1, 4'd8, 1'b0, 1'b0, 1'b0);
      send_hint(3'd5, 64'h9, 32'd5, 2'd1, 4'd8, 1'b0, 1'b0, 1'b1);
      // full list in one run
      for (int i = 0; i < 18; i++)
         send_hint(3'd6, 64'(i + 100), 32'(i + 1), 2'd2, 4'(i), i < 17, 1'b0, i == 17);
      total = 29;
      write_scale(24'd1);
      random_batch(sent);
      total += sent;
      write_scale(24'hFFFFFF);
      random_batch(sent);
      total += sent;
      write_scale(24'd0);
      random_batch(sent);
      total += sent;
      write_scale(24'd1000000);
      while (total < 1200) begin
         if ($urandom_range(0, 60) == 0) write_scale(SCALE_W'($urandom_range(1, 24'hFFFFFF)));
         random_batch(sent);
         total += sent;
      end
      drain();
      if (fail_count == 0) $display("** weighted_fair_prefetch_scheduler: PASSED **");
      else $display("** weighted_fair_prefetch_scheduler: FAILED **");
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("** weighted_fair_prefetch_scheduler: FAILED **");
      $finish;
   end

endmodule
